// ----- hw/rtl/positional_ordered_list_defines.svh -----
// Assertion macros for the positional ordered list.
// Used by the top level; relies on a clock named clk and a reset named rst.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define POL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off during reset.
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pol_pkg.sv -----
// Shared types and constants for the positional ordered list.
// Used by pol_cell and positional_ordered_list; depends on nothing.
package pol_pkg;

  // Sizing of the list and of the beat fields.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // How every cell of the chain moves at a clock edge.
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_ROTATE = 2'd3
  } mode_t;

  // Request beat.
  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // Result beat.
  typedef struct packed {
    status_t                 status;
    logic [5:0]              entry_count;
    logic                    has_value;
    logic signed [VAL_W-1:0] value_out;
    logic                    last;
  } res_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    mode_t                   mode;
    logic [IDX_W-1:0]        pos_idx;
    logic [IDX_W-1:0]        tail_idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/pol_cell.sv -----
// One storage cell of the list chain: holds a single entry.
// Depends on pol_pkg for the control struct and widths.
module pol_cell (
  input  logic                            clk,
  input  logic [pol_pkg::IDX_W-1:0]       index,
  input  pol_pkg::cell_ctrl_t             ctrl,
  input  logic signed [pol_pkg::VAL_W-1:0] left,
  input  logic signed [pol_pkg::VAL_W-1:0] right,
  input  logic signed [pol_pkg::VAL_W-1:0] head,
  output logic signed [pol_pkg::VAL_W-1:0] data
);

  logic signed [pol_pkg::VAL_W-1:0] data_next;

  // Pick the new content from this cell, a neighbour, the list head or the broadcast value.
  always_comb begin
    data_next = data;
    unique case (ctrl.mode)
      pol_pkg::MODE_HOLD: begin
        data_next = data;
      end
      pol_pkg::MODE_INSERT: begin
        if (index == ctrl.pos_idx) begin
          data_next = ctrl.value;
        end else if (index > ctrl.pos_idx) begin
          data_next = left;
        end
      end
      pol_pkg::MODE_DELETE: begin
        if (index >= ctrl.pos_idx) begin
          data_next = right;
        end
      end
      pol_pkg::MODE_ROTATE: begin
        if (index == ctrl.tail_idx) begin
          data_next = head;
        end else if (index < ctrl.tail_idx) begin
          data_next = right;
        end
      end
    endcase
  end

  // Entry storage needs no reset: nothing reads it before it is written.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- hw/rtl/positional_ordered_list.sv -----
// Top level of the positional ordered list: sequencer plus the chain of cells.
// Depends on pol_pkg, pol_cell and positional_ordered_list_defines.svh.
//
// Usage: a request beat (insert, delete, dump) is taken at a rising edge where
// start is high and busy is low. Results leave on res, each valid for exactly
// one cycle while res_strobe is high; the receiver cannot stall them.
// Insert and delete shift the chain's cells in parallel at the accepting
// edge; the single result beat appears in the next cycle and busy stays low,
// so a new request may follow in the next cycle.
// A dump of a non-empty list rotates the chain through cell 0 once per cycle,
// giving one result beat per stored entry; busy drops as the final beat leaves,
// and the first beat is registered once the sequencer is in its dump state.
// An empty dump, and an unused request code, give one beat in the next cycle.
// Reset clears the entry count, the strobe and the sequencer; the cell
// contents are not cleared, as only written entries are ever read.
`include "positional_ordered_list_defines.svh"

module positional_ordered_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pol_pkg::req_t req,
  output pol_pkg::res_t res,
  output logic          res_strobe
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t                           state;
  logic [pol_pkg::CNT_W-1:0]        count;
  logic [pol_pkg::CNT_W-1:0]        dump_idx;
  pol_pkg::cell_ctrl_t              ctrl;
  logic signed [pol_pkg::VAL_W-1:0] cell_data [pol_pkg::CAPACITY];

  logic                      accept;
  logic [pol_pkg::CMP_W-1:0] pos_ext;
  logic [pol_pkg::CMP_W-1:0] cnt_ext;
  logic                      ins_bad;
  logic                      del_bad;
  logic                      is_full;
  logic                      dump_last;
  logic [pol_pkg::CNT_W-1:0] count_dec;

  assign busy      = (state == ST_DUMP);
  assign accept    = start && !busy;
  assign pos_ext   = pol_pkg::CMP_W'(req.position);
  assign cnt_ext   = pol_pkg::CMP_W'(count);
  assign ins_bad   = (req.position == '0) || (pos_ext > cnt_ext + pol_pkg::CMP_W'(1));
  assign del_bad   = (req.position == '0) || (pos_ext > cnt_ext);
  assign is_full   = (count == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
  assign count_dec = count - pol_pkg::CNT_W'(1);
  assign dump_last = (dump_idx == count_dec);

  // Broadcast control to the chain.
  always_comb begin
    ctrl.mode     = pol_pkg::MODE_HOLD;
    ctrl.pos_idx  = pol_pkg::IDX_W'(pos_ext - pol_pkg::CMP_W'(1));
    ctrl.tail_idx = pol_pkg::IDX_W'(count_dec);
    ctrl.value    = req.value;
    if (busy) begin
      ctrl.mode = pol_pkg::MODE_ROTATE;
    end else if (accept) begin
      if (req.op == pol_pkg::OP_INSERT && !ins_bad && !is_full) begin
        ctrl.mode = pol_pkg::MODE_INSERT;
      end else if (req.op == pol_pkg::OP_DELETE && !del_bad) begin
        ctrl.mode = pol_pkg::MODE_DELETE;
      end
    end
  end

  // The chain of cells; each sees its neighbours and the head of the list.
  for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pol_pkg::VAL_W-1:0] left_data;
    logic signed [pol_pkg::VAL_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = req.value;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == pol_pkg::CAPACITY - 1) begin : g_final
      assign right_data = cell_data[0];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk   (clk),
      .index (pol_pkg::IDX_W'(i)),
      .ctrl  (ctrl),
      .left  (left_data),
      .right (right_data),
      .head  (cell_data[0]),
      .data  (cell_data[i])
    );
  end

  // Sequencer, entry count and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      dump_idx   <= '0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.op == pol_pkg::OP_DUMP && count != '0) begin
              state    <= ST_DUMP;
              dump_idx <= '0;
            end else begin
              res_strobe <= 1'b1;
              if (ctrl.mode == pol_pkg::MODE_INSERT) begin
                count <= count + pol_pkg::CNT_W'(1);
              end else if (ctrl.mode == pol_pkg::MODE_DELETE) begin
                count <= count_dec;
              end
            end
          end
        end
        ST_DUMP: begin
          res_strobe <= 1'b1;
          dump_idx   <= dump_idx + pol_pkg::CNT_W'(1);
          if (dump_last) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (busy) begin
      res.status      <= pol_pkg::STATUS_OK;
      res.entry_count <= 6'(count);
      res.has_value   <= 1'b1;
      res.value_out   <= cell_data[0];
      res.last        <= dump_last;
    end else begin
      res.has_value <= 1'b0;
      res.value_out <= '0;
      res.last      <= 1'b1;
      res.status    <= pol_pkg::STATUS_OK;
      if (ctrl.mode == pol_pkg::MODE_INSERT) begin
        res.entry_count <= 6'(count + pol_pkg::CNT_W'(1));
      end else if (ctrl.mode == pol_pkg::MODE_DELETE) begin
        res.entry_count <= 6'(count_dec);
      end else begin
        res.entry_count <= 6'(count);
        if (req.op == pol_pkg::OP_INSERT) begin
          res.status <= ins_bad ? pol_pkg::STATUS_BADPOS : pol_pkg::STATUS_FULL;
        end else if (req.op == pol_pkg::OP_DELETE) begin
          res.status <= pol_pkg::STATUS_BADPOS;
        end
      end
    end
  end

  // Checks on the sequencer and the count.
  `POL_ASSERT_NOW(a_count_range, 1'b1, count <= pol_pkg::CNT_W'(pol_pkg::CAPACITY), "count above capacity")
  `POL_ASSERT_NEXT(a_single_beat, accept && req.op != pol_pkg::OP_DUMP, res_strobe && res.last, "single-beat request gave no final beat")
  `POL_ASSERT_NEXT(a_dump_count_held, busy, $stable(count), "count changed during a dump")
  `POL_ASSERT_NOW(a_dump_ends, res_strobe && res.has_value && res.last, !busy, "still busy after the final dump beat")

endmodule

// ----- tb/sv/positional_ordered_list_tb.sv -----
// Self-checking testbench for the positional ordered list: a queued request driver,
// a result monitor and a behavioural copy of the list that predicts every result beat.
// Depends on pol_pkg and the positional_ordered_list top level only.
module positional_ordered_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int RAND_ITEMS   = 430;
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // One queued request together with the idle cycles that follow it.
  typedef struct {
    req_t        r;
    int unsigned gap;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  res_t res;
  logic res_strobe;

  pending_req_t request_q[$];
  res_t         result_q[$];

  // Behavioural copy of the list, updated as each request beat is taken.
  logic signed [VAL_W-1:0] list_vals[CAPACITY];
  int          list_len = 0;
  int          plan_len = 0;
  int unsigned gap_left = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;

  positional_ordered_list dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .res        (res),
    .res_strobe (res_strobe)
  );

  // Clock and the single reset pulse.
  initial forever #5 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Work out the result beats that one request produces and update the list.
  task automatic predict_list_results(input req_t r);
    int   p;
    int   i;
    res_t e;
    p = r.position;
    e = '0;
    e.status = STATUS_OK;
    e.last = 1'b1;
    case (r.op)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          e.status = STATUS_BADPOS;
        end else if (list_len >= CAPACITY) begin
          e.status = STATUS_FULL;
        end else begin
          for (i = list_len; i > p - 1; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = r.value;
          list_len++;
        end
        e.entry_count = 6'(list_len);
        result_q.push_back(e);
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          e.status = STATUS_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
        e.entry_count = 6'(list_len);
        result_q.push_back(e);
      end
      OP_DUMP: begin
        e.entry_count = 6'(list_len);
        if (list_len == 0) begin
          result_q.push_back(e);
        end else begin
          for (i = 0; i < list_len; i++) begin
            e.has_value = 1'b1;
            e.value_out = list_vals[i];
            e.last = (i == list_len - 1);
            result_q.push_back(e);
          end
        end
      end
      default: begin
        e.entry_count = 6'(list_len);
        result_q.push_back(e);
      end
    endcase
  endtask

  // Queue a request and track the list length it will leave behind.
  task automatic queue_request(input op_t op, input int pos, input logic signed [31:0] val,
                               input int unsigned gap);
    pending_req_t it;
    it.r.op = op;
    it.r.position = 6'(pos);
    it.r.value = val;
    it.gap = gap;
    request_q.push_back(it);
    if (op == OP_INSERT && pos >= 1 && pos <= plan_len + 1 && plan_len < CAPACITY)
      plan_len++;
    else if (op == OP_DELETE && pos >= 1 && pos <= plan_len)
      plan_len--;
  endtask

  // Stimulus: a directed opening, then random grow and shrink phases.
  initial begin : stimulus
    int   n;
    int   roll;
    int   pos;
    int   full_tries;
    bit   grow;
    bit   burst;
    op_t  op;
    logic signed [31:0] val;
    int unsigned gap;

    // Empty list, bad positions and the unused request code.
    queue_request(OP_DUMP,   0,  32'sd0, 0);
    queue_request(OP_DELETE, 1,  32'sd0, 1);
    queue_request(OP_INSERT, 0,  32'sd5, 0);
    queue_request(OP_INSERT, 2,  32'sd5, 2);
    queue_request(OP_NONE,   63, -32'sd1, 0);
    // Inserts at head, tail and middle with extreme values.
    queue_request(OP_INSERT, 1,  32'h7fffffff, 0);
    queue_request(OP_INSERT, 2,  32'h80000000, 3);
    queue_request(OP_INSERT, 1,  32'sd0, 0);
    queue_request(OP_INSERT, 2,  -32'sd1, 0);
    queue_request(OP_INSERT, 63, 32'sd9, 1);
    queue_request(OP_DUMP,   0,  32'sd0, 0);
    // Deletes: bad positions, tail, head.
    queue_request(OP_DELETE, 0,  32'sd0, 0);
    queue_request(OP_DELETE, 5,  32'sd0, 2);
    queue_request(OP_DELETE, 4,  32'sd0, 0);
    queue_request(OP_DELETE, 1,  32'sd0, 0);
    queue_request(OP_DUMP,   0,  32'sd0, 1);
    queue_request(OP_INSERT, 3,  32'h55555555, 0);
    queue_request(OP_INSERT, 2,  32'haaaaaaaa, 0);
    queue_request(OP_DELETE, 2,  32'sd0, 3);
    queue_request(OP_NONE,   0,  32'sd0, 0);
    queue_request(OP_DUMP,   0,  32'sd0, 0);

    // Random part: grow towards a full list, hammer it, then drain to empty.
    grow = 1'b1;
    burst = 1'b0;
    full_tries = 0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 29) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 3);
      if (grow && plan_len == CAPACITY) begin
        full_tries++;
        if (full_tries > 4) begin
          grow = 1'b0;
          full_tries = 0;
        end
      end else if (!grow && plan_len == 0) begin
        grow = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) op = OP_NONE;
      else if (roll < 14) op = OP_DUMP;
      else if (roll < (grow ? 84 : 30)) op = OP_INSERT;
      else op = OP_DELETE;
      if ($urandom_range(0, 6) == 0 || op == OP_DUMP || op == OP_NONE)
        pos = $urandom_range(0, 63);
      else if (op == OP_INSERT)
        pos = $urandom_range(1, plan_len + 1);
      else
        pos = (plan_len == 0) ? $urandom_range(0, 63) : $urandom_range(1, plan_len);
      case ($urandom_range(0, 15))
        0:       val = 32'h80000000;
        1:       val = 32'h7fffffff;
        2:       val = -32'sd1;
        3:       val = 32'sd0;
        default: val = $urandom();
      endcase
      queue_request(op, pos, val, gap);
    end
  end

  // Driver: present each request after the idle gap of the one before, hold it until taken.
  always @(posedge clk) begin : driver
    pending_req_t it;
    logic taken;
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) predict_list_results(req);
      if (taken || !start) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          it = request_q.pop_front();
          req <= it.r;
          start <= 1'b1;
          gap_left <= it.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Report the first few bad beats in full, count the rest.
  task automatic report_bad_beat(input string what, input res_t want, input res_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display("%s at cycle %0d: expected st=%0d cnt=%0d hv=%0b val=%0d last=%0b, got st=%0d cnt=%0d hv=%0b val=%0d last=%0b",
               what, cycle_cnt, want.status, want.entry_count, want.has_value,
               want.value_out, want.last, got.status, got.entry_count, got.has_value,
               got.value_out, got.last);
  endtask

  // Monitor: every strobed beat is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && res_strobe) begin
      if (result_q.size() == 0) begin
        report_bad_beat("Unexpected beat", '0, res);
      end else begin
        want = result_q.pop_front();
        if (res.status !== want.status || res.entry_count !== want.entry_count ||
            res.has_value !== want.has_value || res.value_out !== want.value_out ||
            res.last !== want.last)
          report_bad_beat("Mismatch", want, res);
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    wait (cycle_cnt >= RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // End of run: all requests taken, all results seen, then a short drain.
  initial begin : run_end
    do @(negedge clk);
    while (rst || request_q.size() != 0 || start || result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pol_pkg.sv
hw/rtl/pol_cell.sv
hw/rtl/positional_ordered_list.sv
tb/sv/positional_ordered_list_tb.sv
